// ===== rtl/core/dsc_pkg.sv =====
// shared types and constants of the digitizer event signal counter
`timescale 1ns / 1ps

package dsc_pkg;

  localparam int WORD_W   = 32;
  localparam int IDX_W    = 12;
  localparam int THR_W    = 12;
  localparam int MASK_W   = 8;
  localparam int CNT_W    = 4;
  localparam int QUOT_W   = 13;
  localparam int MARK_W   = 4;
  localparam int BOARD_W  = 5;
  localparam int EVENT_W  = 24;
  localparam int HALF_W   = 16;

  localparam logic [MARK_W-1:0] MARKER_VAL = 4'hA;
  localparam logic [IDX_W-1:0]  IDX_MAX    = 12'hFFF;
  localparam logic [IDX_W-1:0]  IDX_SIZE   = 12'd0;
  localparam logic [IDX_W-1:0]  IDX_MASK   = 12'd1;
  localparam logic [IDX_W-1:0]  IDX_EVENT  = 12'd2;
  localparam logic [IDX_W-1:0]  IDX_TIME   = 12'd3;
  localparam logic [IDX_W-1:0]  HDR_WORDS  = 12'd4;

  typedef struct packed {
    logic accept;
    logic sample_hi;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_mask;
    logic is_data;
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/core/dsc_div.sv =====
// restoring divider for samples per channel, one quotient bit a cycle
`timescale 1ns / 1ps

module dsc_div import dsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [QUOT_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quotient
);

  localparam int STEP_W = $clog2(QUOT_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [QUOT_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, q_r[QUOT_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      q_nxt    = {q_r[QUOT_W-2:0], ge};
      rem_nxt  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(QUOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/core/dsc_datapath.sv =====
// header decode, per-channel min/max tracking and summary registers
`timescale 1ns / 1ps

module dsc_datapath import dsc_pkg::*; #(
  parameter int NUM_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [WORD_W-1:0]  in_data_word,
  input  logic               cfg_wr_en,
  input  logic [THR_W-1:0]   cfg_wr_data,
  output logic               o_event_valid,
  output logic [BOARD_W-1:0] o_board_number,
  output logic [EVENT_W-1:0] o_event_number,
  output logic [WORD_W-1:0]  o_trigger_time,
  output logic [MASK_W-1:0]  o_enabled_mask,
  output logic [CNT_W-1:0]   o_enabled_count,
  output logic [QUOT_W-1:0]  o_samples_each,
  output logic [CNT_W-1:0]   o_signal_count
);

  localparam int SB    = SAMPLE_BITS;
  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  logic [THR_W-1:0]   thr_r;
  logic [IDX_W-1:0]   word_idx_r, word_idx_nxt;
  logic               over_r, over_nxt;
  logic [MARK_W-1:0]  marker_r, marker_nxt;
  logic [IDX_W-1:0]   size_r, size_nxt;
  logic [MASK_W-1:0]  mask_r, mask_nxt;
  logic [CNT_W-1:0]   chan_total_r, chan_total_nxt;
  logic [QUOT_W-1:0]  per_chan_r, per_chan_nxt;
  logic [QUOT_W-1:0]  sic_r, sic_nxt;
  logic [CNT_W-1:0]   chan_idx_r, chan_idx_nxt;
  logic [SB-1:0]      min_r, min_nxt;
  logic [SB-1:0]      max_r, max_nxt;
  logic               hit_r, hit_nxt;
  logic [CNT_W-1:0]   hit_total_r, hit_total_nxt;
  logic [BOARD_W-1:0] board_r, board_nxt;
  logic [EVENT_W-1:0] event_r, event_nxt;
  logic [WORD_W-1:0]  time_r, time_nxt;
  logic [SB-1:0]      word_hi_r;

  logic               is_data;
  logic               sample_en;
  logic [SB-1:0]      samp;
  logic               active;
  logic               first;
  logic [SB-1:0]      min_base, max_base, min_new, max_new;
  logic               hit_base;
  logic               exceed;
  logic [QUOT_W-1:0]  sic_inc;
  logic [CNT_W-1:0]   pop;
  logic [QUOT_W-1:0]  dividend;
  logic               div_done;
  logic [QUOT_W-1:0]  quotient;

  assign is_data   = word_idx_r >= HDR_WORDS;
  assign sts.is_data  = is_data;
  assign sts.is_mask  = word_idx_r == IDX_MASK;
  assign sts.div_done = div_done;

  assign sample_en = (cmd.accept && is_data) || cmd.sample_hi;
  assign samp      = cmd.sample_hi ? word_hi_r : in_data_word[SB-1:0];

  always_comb begin
    pop = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      pop = pop + CNT_W'(in_data_word[i]);
    end
  end

  assign dividend = (size_r >= HDR_WORDS) ? {size_r - HDR_WORDS, 1'b0} : '0;

  // divisor held in the channel count register for the whole division
  dsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (chan_total_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // one sample step
  assign active   = (chan_idx_r < chan_total_r) && (per_chan_r != '0);
  assign first    = sic_r == '0;
  assign min_base = first ? samp : min_r;
  assign max_base = first ? samp : max_r;
  assign hit_base = first ? 1'b0 : hit_r;
  assign min_new  = (samp < min_base) ? samp : min_base;
  assign max_new  = (samp > max_base) ? samp : max_base;
  assign exceed   = CMP_W'(max_new - min_new) > CMP_W'(thr_r);
  assign sic_inc  = sic_r + 1'b1;

  always_comb begin
    word_idx_nxt   = word_idx_r;
    over_nxt       = over_r;
    marker_nxt     = marker_r;
    size_nxt       = size_r;
    mask_nxt       = mask_r;
    chan_total_nxt = chan_total_r;
    per_chan_nxt   = per_chan_r;
    sic_nxt        = sic_r;
    chan_idx_nxt   = chan_idx_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    hit_nxt        = hit_r;
    hit_total_nxt  = hit_total_r;
    board_nxt      = board_r;
    event_nxt      = event_r;
    time_nxt       = time_r;

    if (cmd.accept) begin
      case (word_idx_r)
        IDX_SIZE: begin
          marker_nxt = in_data_word[WORD_W-1 -: MARK_W];
          size_nxt   = in_data_word[IDX_W-1:0];
        end
        IDX_MASK: begin
          mask_nxt       = in_data_word[MASK_W-1:0];
          board_nxt      = in_data_word[WORD_W-1 -: BOARD_W];
          chan_total_nxt = pop;
          per_chan_nxt   = '0;
        end
        IDX_EVENT: begin
          event_nxt = in_data_word[EVENT_W-1:0];
        end
        IDX_TIME: begin
          time_nxt = in_data_word;
        end
        default: begin
        end
      endcase
      if (word_idx_r != IDX_MAX) begin
        word_idx_nxt = word_idx_r + 1'b1;
      end else begin
        over_nxt = 1'b1;
      end
    end

    if (div_done) begin
      per_chan_nxt = (chan_total_r == '0) ? '0 : quotient;
    end

    if (sample_en && active) begin
      min_nxt = min_new;
      max_nxt = max_new;
      hit_nxt = hit_base;
      if (!hit_base && exceed) begin
        hit_nxt       = 1'b1;
        hit_total_nxt = hit_total_r + 1'b1;
      end
      if (sic_inc >= per_chan_r) begin
        sic_nxt      = '0;
        chan_idx_nxt = chan_idx_r + 1'b1;
      end else begin
        sic_nxt = sic_inc;
      end
    end

    if (cmd.emit) begin
      word_idx_nxt   = '0;
      over_nxt       = 1'b0;
      marker_nxt     = '0;
      size_nxt       = '0;
      mask_nxt       = '0;
      chan_total_nxt = '0;
      per_chan_nxt   = '0;
      sic_nxt        = '0;
      chan_idx_nxt   = '0;
      min_nxt        = '0;
      max_nxt        = '0;
      hit_nxt        = 1'b0;
      hit_total_nxt  = '0;
      board_nxt      = '0;
      event_nxt      = '0;
      time_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= '0;
      word_idx_r   <= '0;
      over_r       <= 1'b0;
      marker_r     <= '0;
      size_r       <= '0;
      mask_r       <= '0;
      chan_total_r <= '0;
      per_chan_r   <= '0;
      sic_r        <= '0;
      chan_idx_r   <= '0;
      min_r        <= '0;
      max_r        <= '0;
      hit_r        <= 1'b0;
      hit_total_r  <= '0;
      board_r      <= '0;
      event_r      <= '0;
      time_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      word_idx_r   <= word_idx_nxt;
      over_r       <= over_nxt;
      marker_r     <= marker_nxt;
      size_r       <= size_nxt;
      mask_r       <= mask_nxt;
      chan_total_r <= chan_total_nxt;
      per_chan_r   <= per_chan_nxt;
      sic_r        <= sic_nxt;
      chan_idx_r   <= chan_idx_nxt;
      min_r        <= min_nxt;
      max_r        <= max_nxt;
      hit_r        <= hit_nxt;
      hit_total_r  <= hit_total_nxt;
      board_r      <= board_nxt;
      event_r      <= event_nxt;
      time_r       <= time_nxt;
    end
  end

  // high half of a data word is held until the next cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word_hi_r <= in_data_word[HALF_W +: SB];
    end
  end

  // summary registers
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_event_valid   <= (marker_r == MARKER_VAL) && !over_r && (size_r == word_idx_r);
      o_board_number  <= board_r;
      o_event_number  <= event_r;
      o_trigger_time  <= time_r;
      o_enabled_mask  <= mask_r;
      o_enabled_count <= chan_total_r;
      o_samples_each  <= per_chan_r;
      o_signal_count  <= hit_total_r;
    end
  end

endmodule

// ===== rtl/core/dsc_ctrl.sv =====
// controller: word acceptance, high-half step, divide wait and summary hand-off
`timescale 1ns / 1ps

module dsc_ctrl import dsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last_word,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_RECV = 4'b0001,
    ST_HI   = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   slot_free;

  assign in_ready  = state_r == ST_RECV;
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign cmd.accept    = accept;
  assign cmd.sample_hi = state_r == ST_HI;
  assign cmd.div_start = accept && sts.is_mask;
  assign cmd.emit      = (state_r == ST_EMIT) && slot_free;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    case (state_r)
      ST_RECV: begin
        if (accept) begin
          last_nxt = in_last_word;
          if (sts.is_mask) begin
            state_nxt = ST_DIV;
          end else if (sts.is_data) begin
            state_nxt = ST_HI;
          end else if (in_last_word) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_HI: begin
        state_nxt = last_r ? ST_EMIT : ST_RECV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = last_r ? ST_EMIT : ST_RECV;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_RECV;
          last_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_RECV;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RECV;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/digitizer_event_signal_counter.sv =====
// top level of the digitizer event signal counter
// Input channel: one 32-bit event word per handshake (in_valid/in_ready), header
// first, in_last_word set on the final word. Output channel: one summary word
// per event (out_valid/out_ready). cfg_wr_en writes the 12-bit threshold.
// Header words 0, 2 and 3 need no extra step. Word 1 starts the
// samples-per-channel divider, a one-bit-a-cycle restoring unit, so in_ready
// stays low until the divider is done. For each data word the low sample goes
// through the shared min/max/compare logic on acceptance and the high sample in
// the next cycle.
// The summary is loaded into the output register from the emit state, which follows
// the last word, once the register is free, and event state clears with the load.
// A stalled receiver holds the summary; the next event streams in meanwhile
// and only its own summary waits for the register to free.
// Reset clears the threshold, all event state and out_valid.
`timescale 1ns / 1ps

module digitizer_event_signal_counter import dsc_pkg::*; #(
  parameter int NUM_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [WORD_W-1:0]  in_data_word,
  input  logic               in_last_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_event_valid,
  output logic [BOARD_W-1:0] out_board_number,
  output logic [EVENT_W-1:0] out_event_number,
  output logic [WORD_W-1:0]  out_trigger_time,
  output logic [MASK_W-1:0]  out_enabled_mask,
  output logic [CNT_W-1:0]   out_enabled_count,
  output logic [QUOT_W-1:0]  out_samples_each,
  output logic [CNT_W-1:0]   out_signal_count,
  input  logic               cfg_wr_en,
  input  logic [THR_W-1:0]   cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  dsc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_word (in_last_word),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  dsc_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_data_word    (in_data_word),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .o_event_valid   (out_event_valid),
    .o_board_number  (out_board_number),
    .o_event_number  (out_event_number),
    .o_trigger_time  (out_trigger_time),
    .o_enabled_mask  (out_enabled_mask),
    .o_enabled_count (out_enabled_count),
    .o_samples_each  (out_samples_each),
    .o_signal_count  (out_signal_count)
  );

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("summary overwritten while waiting");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("summary not presented after load");

  a_div_not_receiving: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> !in_ready)
    else $error("divider finished while words were taken");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_signal_count <= out_enabled_count) &&
                  (out_enabled_count <= CNT_W'(NUM_CHANNELS)))
    else $error("channel counts out of range");

endmodule
